>>> rtl/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types, constants and helpers of the framed packet receiver.
// ----------------------------------------------------------------------------
package fpr_pkg;

    localparam int HOLD_DEPTH      = 70;
    localparam int HOLD_AW         = 7;
    localparam int PAY_BYTES       = 64;
    localparam int PAY_WORDS       = 8;
    localparam int MAX_PAYLOAD_DEF = 64;
    localparam logic [7:0]  START_BYTE_RST = 8'hFA;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [6:0]  HDR_TRL_BYTES  = 7'd6;
    localparam logic [6:0]  HDR_BYTES      = 7'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_RD_A,
        ST_GET_A,
        ST_GET_C,
        ST_GET_L,
        ST_CRC_RD,
        ST_CRC_LD,
        ST_CRC_BIT,
        ST_TRL_RD,
        ST_TRL_LO,
        ST_TRL_HI,
        ST_PAD,
        ST_GOOD,
        ST_WAIT_OUT
    } t_state;

    typedef struct packed {
        logic       init;
        logic       load;
        logic       step;
        logic [7:0] din;
    } t_crc_ctl;

    typedef struct packed {
        logic       shift;
        logic [7:0] din;
    } t_pay_ctl;

    function automatic logic [HOLD_AW-1:0] f_wrap(input logic [HOLD_AW:0] s);
        logic [HOLD_AW:0] d;
        d = s - (HOLD_AW+1)'(HOLD_DEPTH);
        return (s >= (HOLD_AW+1)'(HOLD_DEPTH)) ? d[HOLD_AW-1:0] : s[HOLD_AW-1:0];
    endfunction

endpackage

>>> rtl/fpr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_byte_if / fpr_frame_if
// Valid/ready channels for received bytes and decoded frames.
// ----------------------------------------------------------------------------
interface fpr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpr_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_address;
    logic [7:0]  frame_command;
    logic [6:0]  payload_length;
    logic [63:0] payload_word_0;
    logic [63:0] payload_word_1;
    logic [63:0] payload_word_2;
    logic [63:0] payload_word_3;
    logic [63:0] payload_word_4;
    logic [63:0] payload_word_5;
    logic [63:0] payload_word_6;
    logic [63:0] payload_word_7;
    logic        last_frame;
    modport source (output valid, output frame_address, output frame_command,
                    output payload_length, output payload_word_0, output payload_word_1,
                    output payload_word_2, output payload_word_3, output payload_word_4,
                    output payload_word_5, output payload_word_6, output payload_word_7,
                    output last_frame, input ready);
    modport sink   (input valid, input frame_address, input frame_command,
                    input payload_length, input payload_word_0, input payload_word_1,
                    input payload_word_2, input payload_word_3, input payload_word_4,
                    input payload_word_5, input payload_word_6, input payload_word_7,
                    input last_frame, output ready);
endinterface

>>> rtl/fpr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 70
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/fpr_crc_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_crc_serial
// Bit-serial CRC-16/MODBUS: load xors a byte, each step shifts one bit.
// ----------------------------------------------------------------------------
module fpr_crc_serial
    import fpr_pkg::*;
(
    input  logic        i_clk,
    input  t_crc_ctl    i_ctl,
    output logic [15:0] o_crc
);
    logic [15:0] r_crc;
    logic [15:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = CRC_INIT;
        end else if (i_ctl.load) begin
            n_crc = r_crc ^ {8'd0, i_ctl.din};
        end else if (i_ctl.step) begin
            n_crc = r_crc[0] ? ((r_crc >> 1) ^ CRC_POLY) : (r_crc >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = r_crc;
endmodule

>>> rtl/fpr_pay_shift.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_pay_shift
// Payload byte shift register; bytes enter at the top and move down.
// ----------------------------------------------------------------------------
module fpr_pay_shift
    import fpr_pkg::*;
(
    input  logic                   i_clk,
    input  t_pay_ctl               i_ctl,
    output logic [PAY_BYTES*8-1:0] o_pay
);
    logic [PAY_BYTES*8-1:0] r_pay;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_pay <= {i_ctl.din, r_pay[PAY_BYTES*8-1:8]};
        end
    end

    assign o_pay = r_pay;
endmodule

>>> rtl/framed_packet_receiver_crc16_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_receiver_crc16_core
// Start-byte framed packet parser with CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// i_rx carries one received byte per transaction; it is ready only while the
// parser is idle. Each byte is stored in a 70-entry circular buffer, then
// the buffer is scanned: bytes before the start byte are dropped, the header
// is read, and the CRC runs bit-serially over each byte. Payload bytes
// shift into a 64-byte register as they pass the CRC, zeros fill the rest,
// and a good frame goes out on o_frm; last_frame marks the final frame
// caused by one input byte.
// A bad CRC or an oversize length drops the start byte and the scan
// resumes. Speed is set by the single read port of the buffer and the
// one-bit CRC step.
// o_frm is a register: a frame waits there while scanning goes on, and the
// parser stalls only when a second frame is ready before the first is taken.
// i_cfg_we writes the start byte; write it only while idle.
// Reset (i_rst_n low, synchronous) empties the buffer, clears o_frm.valid and
// sets the start byte to 0xFA; no clearing pass is needed.
// ----------------------------------------------------------------------------
module framed_packet_receiver_crc16_core
    import fpr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    fpr_byte_if.sink    i_rx,
    fpr_frame_if.source o_frm
);
    localparam logic [7:0] LP_MAX = 8'(MAX_PAYLOAD);

    t_state r_state, n_state;
    logic [HOLD_AW-1:0] r_head, n_head;
    logic [HOLD_AW-1:0] r_count, n_count;
    logic [HOLD_AW-1:0] r_off, n_off;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_lo, n_lo;
    logic [6:0]  r_pad, n_pad;
    logic        r_pend, n_pend;
    logic [7:0]  r_start;

    logic [7:0]  r_o_addr, r_o_cmd;
    logic [6:0]  r_o_len;
    logic [PAY_BYTES*8-1:0] r_o_pay;
    logic        r_o_valid, n_o_valid;
    logic        r_o_last, n_o_last;
    logic        w_copy;

    logic              w_acc;
    logic              w_we;
    logic [HOLD_AW-1:0] w_waddr;
    logic [HOLD_AW-1:0] w_raddr;
    logic [7:0]        w_rdata;
    logic [15:0]       w_crc;
    logic [PAY_BYTES*8-1:0] w_pay;
    t_crc_ctl          w_crc_ctl;
    t_pay_ctl          w_pay_ctl;
    logic [6:0]        w_need;
    logic              w_drop1;

    assign w_acc   = i_rx.valid && i_rx.ready;
    assign w_need  = r_len[6:0] + HDR_TRL_BYTES;
    assign w_raddr = f_wrap({1'b0, r_head} + {1'b0, r_off});
    assign w_we    = w_acc;
    assign w_waddr = (r_count == HOLD_AW'(HOLD_DEPTH)) ? r_head
                   : f_wrap({1'b0, r_head} + {1'b0, r_count});

    fpr_ram #(.WIDTH(8), .DEPTH(HOLD_DEPTH)) u_hold (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_rx.rx_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    fpr_crc_serial u_crc (
        .i_clk (i_clk),
        .i_ctl (w_crc_ctl),
        .o_crc (w_crc)
    );

    fpr_pay_shift u_pay (
        .i_clk (i_clk),
        .i_ctl (w_pay_ctl),
        .o_pay (w_pay)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (w_acc) n_state = ST_FIND_RD;
            ST_FIND_RD:  n_state = (r_count == '0) ? ST_IDLE : ST_FIND_CHK;
            ST_FIND_CHK: begin
                if (w_rdata != r_start) begin
                    n_state = ST_FIND_RD;
                end else if (r_count < HDR_TRL_BYTES) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A:     n_state = ST_GET_A;
            ST_GET_A:    n_state = ST_GET_C;
            ST_GET_C:    n_state = ST_GET_L;
            ST_GET_L: begin
                if (w_rdata > LP_MAX) begin
                    n_state = ST_FIND_RD;
                end else if (r_count < (w_rdata[6:0] + HDR_TRL_BYTES)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_CRC_RD;
                end
            end
            ST_CRC_RD:   n_state = ST_CRC_LD;
            ST_CRC_LD:   n_state = ST_CRC_BIT;
            ST_CRC_BIT: begin
                if (r_bit == 3'd7) begin
                    n_state = (r_off == r_len[6:0] + 7'd3) ? ST_TRL_RD : ST_CRC_RD;
                end
            end
            ST_TRL_RD:   n_state = ST_TRL_LO;
            ST_TRL_LO:   n_state = ST_TRL_HI;
            ST_TRL_HI:   n_state = ({w_rdata, r_lo} == w_crc) ? ST_PAD : ST_FIND_RD;
            ST_PAD:      if (r_pad == '0) n_state = ST_GOOD;
            ST_GOOD:     n_state = ST_WAIT_OUT;
            ST_WAIT_OUT: if (!r_o_valid) n_state = ST_FIND_RD;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        i_rx.ready    = (r_state == ST_IDLE);
        w_crc_ctl     = '{init: 1'b0, load: 1'b0, step: 1'b0, din: w_rdata};
        w_pay_ctl     = '{shift: 1'b0, din: w_rdata};
        w_drop1       = 1'b0;
        w_copy        = 1'b0;
        n_head        = r_head;
        n_count       = r_count;
        n_off         = r_off;
        n_bit         = r_bit;
        n_addr        = r_addr;
        n_cmd         = r_cmd;
        n_len         = r_len;
        n_lo          = r_lo;
        n_pad         = r_pad;
        n_pend        = r_pend;
        n_o_valid     = r_o_valid && !o_frm.ready;
        n_o_last      = r_o_last;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_off = '0;
                    if (r_count == HOLD_AW'(HOLD_DEPTH)) begin
                        n_head = f_wrap({1'b0, r_head} + 8'd1);
                    end else begin
                        n_count = r_count + 7'd1;
                    end
                end
                if (r_pend) begin
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b1;
                    n_pend    = 1'b0;
                end
            end
            ST_FIND_CHK: begin
                if (w_rdata != r_start) begin
                    w_drop1 = 1'b1;
                end else begin
                    n_off = 7'd1;
                end
            end
            ST_RD_A: n_off = 7'd2;
            ST_GET_A: begin
                n_addr = w_rdata;
                n_off  = 7'd3;
            end
            ST_GET_C: n_cmd = w_rdata;
            ST_GET_L: begin
                n_len = w_rdata;
                n_off = '0;
                w_crc_ctl.init = 1'b1;
                if (w_rdata > LP_MAX) begin
                    w_drop1 = 1'b1;
                end
            end
            ST_CRC_LD: begin
                w_crc_ctl.load  = 1'b1;
                w_pay_ctl.shift = (r_off >= HDR_BYTES);
                n_bit = '0;
            end
            ST_CRC_BIT: begin
                w_crc_ctl.step = 1'b1;
                n_bit = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_off = r_off + 7'd1;
                end
            end
            ST_TRL_RD: n_off = r_off + 7'd1;
            ST_TRL_LO: n_lo = w_rdata;
            ST_TRL_HI: begin
                n_pad = 7'(PAY_BYTES) - r_len[6:0];
                if ({w_rdata, r_lo} != w_crc) begin
                    w_drop1 = 1'b1;
                end
            end
            ST_PAD: begin
                if (r_pad != '0) begin
                    w_pay_ctl.shift = 1'b1;
                    w_pay_ctl.din   = 8'd0;
                    n_pad = r_pad - 7'd1;
                end
            end
            ST_GOOD: begin
                n_head  = f_wrap({1'b0, r_head} + {1'b0, w_need});
                n_count = r_count - w_need;
                if (r_pend) begin
                    n_o_valid = 1'b1;
                    n_o_last  = 1'b0;
                    n_pend    = 1'b0;
                end
            end
            ST_WAIT_OUT: begin
                if (!r_o_valid) begin
                    w_copy = 1'b1;
                    n_pend = 1'b1;
                    n_off  = '0;
                end
            end
            default: begin
            end
        endcase
        if (w_drop1) begin
            n_head  = f_wrap({1'b0, r_head} + 8'd1);
            n_count = r_count - 7'd1;
            n_off   = '0;
        end
        if (r_state == ST_FIND_RD && r_count == '0 && r_pend) begin
            n_o_valid = 1'b1;
            n_o_last  = 1'b1;
            n_pend    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_o_last  <= 1'b0;
            r_start   <= START_BYTE_RST;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            r_o_last  <= n_o_last;
            if (i_cfg_we) begin
                r_start <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_off  <= n_off;
        r_bit  <= n_bit;
        r_addr <= n_addr;
        r_cmd  <= n_cmd;
        r_len  <= n_len;
        r_lo   <= n_lo;
        r_pad  <= n_pad;
        if (w_copy) begin
            r_o_addr <= r_addr;
            r_o_cmd  <= r_cmd;
            r_o_len  <= r_len[6:0];
            r_o_pay  <= w_pay;
        end
    end

    assign o_frm.valid          = r_o_valid;
    assign o_frm.frame_address  = r_o_addr;
    assign o_frm.frame_command  = r_o_cmd;
    assign o_frm.payload_length = r_o_len;
    assign o_frm.payload_word_0 = r_o_pay[63:0];
    assign o_frm.payload_word_1 = r_o_pay[127:64];
    assign o_frm.payload_word_2 = r_o_pay[191:128];
    assign o_frm.payload_word_3 = r_o_pay[255:192];
    assign o_frm.payload_word_4 = r_o_pay[319:256];
    assign o_frm.payload_word_5 = r_o_pay[383:320];
    assign o_frm.payload_word_6 = r_o_pay[447:384];
    assign o_frm.payload_word_7 = r_o_pay[511:448];
    assign o_frm.last_frame     = r_o_last;
endmodule
